// ===== sv/hrae_pkg.sv =====
// Package for the hall rotor angle estimator: opcodes, control-word type,
// microprogram ROM, hall sequence table and shared constants.
// No dependencies.
`default_nettype none

package hrae_pkg;

   // Command codes carried in req_tuser
   localparam logic [1:0] CMD_INIT = 2'd0;
   localparam logic [1:0] CMD_EDGE = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   // Register indexes on the csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] REG_SECTOR_1  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SECTOR_6  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_PERIOD = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_REF_DIR  = 3'd7;
   localparam int NUM_SECTORS = 6;

   // Arithmetic constants
   localparam logic [15:0] OFS_90 = 16'd16384;
   localparam logic [15:0] OFS_60 = 16'd10923;
   localparam logic [15:0] OFS_30 = 16'd5461;
   localparam int FILT_GAIN = 1500;
   localparam int FILT_BOUND = 983040000;     // 30000 * 32768
   localparam int LOW_SPEED = 1638;
   localparam logic [15:0] MIN_PERIOD_RST = 16'd100;
   localparam logic [2:0] HALL_PULL = 3'd5;   // sector with catch-up pull
   localparam int DIV_W = 32;

   // Microprogram addresses
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_INIT = 4'd0;
   localparam logic [PC_W-1:0] PC_EDGE = 4'd2;
   localparam logic [PC_W-1:0] PC_TICK = 4'd5;
   localparam logic [PC_W-1:0] PC_WAIT = 4'd10;
   localparam logic [PC_W-1:0] PC_SLOW = 4'd13;
   localparam logic [PC_W-1:0] PC_DONE = 4'd14;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_INIT,
      OP_EDGE_DIR,
      OP_EDGE_REF,
      OP_FILT_MUL,
      OP_FILT_ACC,
      OP_FILT_OUT,
      OP_CLAMP,
      OP_DIV_START,
      OP_DIV_WAIT,
      OP_STEP_SAT,
      OP_MOVE,
      OP_LOW_SPEED,
      OP_DONE
   } hrae_op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_LOW_SPEED,
      COND_DIV_BUSY
   } hrae_cond_type;

   typedef struct packed {
      hrae_op_type   op;
      hrae_cond_type cond;
      logic [PC_W-1:0] target;
   } hrae_ctl_type;

   // Datapath status back to the sequencer
   typedef struct packed {
      logic low_speed;
      logic div_busy;
      logic out_free;
   } hrae_status_type;

   typedef struct packed {
      logic [2:0]  hall_code;
      logic [15:0] period;
      logic [15:0] speed;
   } hrae_item_type;

   typedef struct packed {
      logic [15:0] reference_angle;
      logic [15:0] angle_step;
      logic        direction;
      logic [15:0] angle;
   } hrae_result_type;

   // Microprogram: one control word per step
   function automatic hrae_ctl_type ucode(input logic [PC_W-1:0] pc);
      hrae_ctl_type w;
      w.op     = OP_DONE;
      w.cond   = COND_NEXT;
      w.target = PC_DONE;
      case (pc)
         4'd0:  w.op = OP_INIT;
         4'd1:  w.op = OP_DONE;
         4'd2:  w.op = OP_EDGE_DIR;
         4'd3:  w.op = OP_EDGE_REF;
         4'd4:  w.op = OP_DONE;
         4'd5:  w.op = OP_FILT_MUL;
         4'd6:  w.op = OP_FILT_ACC;
         4'd7:  begin
            w.op = OP_FILT_OUT; w.cond = COND_LOW_SPEED; w.target = PC_SLOW;
         end
         4'd8:  w.op = OP_CLAMP;
         4'd9:  w.op = OP_DIV_START;
         4'd10: begin
            w.op = OP_DIV_WAIT; w.cond = COND_DIV_BUSY; w.target = PC_WAIT;
         end
         4'd11: w.op = OP_STEP_SAT;
         4'd12: begin
            w.op = OP_MOVE; w.cond = COND_ALWAYS; w.target = PC_DONE;
         end
         4'd13: w.op = OP_LOW_SPEED;
         default: w.op = OP_DONE;
      endcase
      return w;
   endfunction

   function automatic logic [PC_W-1:0] entry(input logic [1:0] cmd);
      logic [PC_W-1:0] pc;
      case (cmd)
         CMD_INIT: pc = PC_INIT;
         CMD_EDGE: pc = PC_EDGE;
         CMD_TICK: pc = PC_TICK;
         default:  pc = PC_DONE;
      endcase
      return pc;
   endfunction

   // Next hall code in the forward 5-1-3-2-6-4 sequence
   function automatic logic [2:0] fwd_next(input logic [2:0] h);
      logic [2:0] n;
      case (h)
         3'd1:    n = 3'd3;
         3'd2:    n = 3'd6;
         3'd3:    n = 3'd2;
         3'd4:    n = 3'd5;
         3'd5:    n = 3'd1;
         3'd6:    n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== sv/hrae_divider.sv =====
// Restoring divider for the angle step: one quotient bit per cycle.
// Depends on hrae_pkg.
`default_nettype none

module hrae_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [hrae_pkg::DIV_W-1:0]   dividend,
   input  wire logic [15:0]                  divisor,
   output logic                              busy,
   output logic [hrae_pkg::DIV_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(hrae_pkg::DIV_W + 1);

   logic                       busy_ff, busy_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [15:0]                rem_ff, rem_in;
   logic [hrae_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [15:0]                div_ff, div_in;
   logic [16:0]                trial, diff;
   logic                       ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[hrae_pkg::DIV_W-1]};
      ge      = trial >= {1'b0, div_ff};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(hrae_pkg::DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         // a zero divisor passes every compare: all ones, saturated later
         rem_in = ge ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[hrae_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== sv/hrae_sequencer.sv =====
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on hrae_pkg.
`default_nettype none

module hrae_sequencer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [1:0]              command,
   input  wire hrae_pkg::hrae_status_type status,
   output logic                         busy,
   output hrae_pkg::hrae_op_type        op,
   output logic                         load
);

   logic                          busy_ff, busy_in;
   logic [hrae_pkg::PC_W-1:0]     pc_ff, pc_in;
   hrae_pkg::hrae_ctl_type        ctl;
   logic                          cond_true;

   always_comb begin
      ctl = hrae_pkg::ucode(pc_ff);
      case (ctl.cond)
         hrae_pkg::COND_ALWAYS:    cond_true = 1'b1;
         hrae_pkg::COND_LOW_SPEED: cond_true = status.low_speed;
         hrae_pkg::COND_DIV_BUSY:  cond_true = status.div_busy;
         default:                  cond_true = 1'b0;
      endcase
      pc_in   = pc_ff;
      busy_in = busy_ff;
      load    = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            pc_in   = hrae_pkg::entry(command);
            busy_in = 1'b1;
         end
      end else if (ctl.op == hrae_pkg::OP_DONE) begin
         // hold until the result register is free
         if (status.out_free) begin
            busy_in = 1'b0;
            load    = 1'b1;
         end
      end else if (cond_true) begin
         pc_in = ctl.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
      op = busy_ff ? ctl.op : hrae_pkg::OP_NOP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("sequencer did not start on an accepted item");

   a_stay_busy : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && ctl.op != hrae_pkg::OP_DONE) |=> busy_ff)
      else $error("sequencer left the program before its final step");

   a_load_idle : assert property (@(posedge clock) disable iff (reset)
      load |=> !busy_ff)
      else $error("sequencer still busy after delivering a result");

   a_div_hold : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && ctl.op == hrae_pkg::OP_DIV_WAIT && status.div_busy)
      |=> (pc_ff == $past(pc_ff)))
      else $error("sequencer moved on while the divider was busy");

endmodule

`default_nettype wire

// ===== sv/hrae_datapath.sv =====
// Datapath of the angle estimator: state registers, config registers,
// filter, step and angle update, driven one opcode per cycle.
// Depends on hrae_pkg and hrae_divider.
`default_nettype none

module hrae_datapath #(
   parameter logic [31:0] ANGLE_STEP_CONST = 32'd268435456
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire hrae_pkg::hrae_item_type              item,
   input  wire hrae_pkg::hrae_op_type                op,
   input  wire logic                                 csr_we,
   input  wire logic [hrae_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [hrae_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                      low_speed,
   output logic                                      div_busy,
   output hrae_pkg::hrae_result_type                 result
);

   localparam logic signed [11:0] GAIN_S  = 12'(hrae_pkg::FILT_GAIN);
   localparam logic signed [32:0] BOUND_P = 33'(hrae_pkg::FILT_BOUND);
   localparam logic signed [32:0] BOUND_N = -33'(hrae_pkg::FILT_BOUND);
   localparam logic signed [15:0] SLOW_P  = 16'(hrae_pkg::LOW_SPEED);
   localparam logic signed [15:0] SLOW_N  = -16'(hrae_pkg::LOW_SPEED);

   // configuration
   logic [15:0] sect_ff [hrae_pkg::NUM_SECTORS];
   logic [15:0] minp_ff;
   logic        refdir_ff;

   // latched item
   logic [2:0]  ih_ff;
   logic [15:0] iper_ff, ispd_ff;

   // estimator state
   logic [15:0] angle_ff, angle_in;
   logic [15:0] ref_ff, ref_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] fp_ff, fp_in;
   logic [15:0] step_ff, step_in;
   logic        dir_ff, dir_in;
   logic [2:0]  hall_ff, hall_in;
   logic [2:0]  prev_ff, prev_in;
   logic signed [29:0] prod_ff, prod_in;

   logic [2:0]  sel_h;
   logic [15:0] tbl, sref;
   logic signed [17:0] diff;
   logic signed [32:0] sum;
   logic [15:0] s, half, dbl, th, rf;
   logic        fwd;
   logic [hrae_pkg::DIV_W-1:0] quo;

   hrae_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (op == hrae_pkg::OP_DIV_START),
      .dividend (ANGLE_STEP_CONST),
      .divisor  (fp_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hrae_pkg::NUM_SECTORS; i++) begin
            sect_ff[i] <= '0;
         end
         minp_ff   <= hrae_pkg::MIN_PERIOD_RST;
         refdir_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_addr == hrae_pkg::REG_MIN_PERIOD) begin
            minp_ff <= csr_wdata;
         end else if (csr_addr == hrae_pkg::REG_REF_DIR) begin
            refdir_ff <= csr_wdata[0];
         end else begin
            sect_ff[csr_addr] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ih_ff   <= item.hall_code;
         iper_ff <= item.period;
         ispd_ff <= item.speed;
      end
   end

   // sector table: codes 0 and 7 read as zero
   always_comb begin
      sel_h = (op == hrae_pkg::OP_INIT) ? ih_ff : hall_ff;
      if (sel_h inside {[3'd1:3'd6]}) begin
         tbl = sect_ff[sel_h - 3'd1];
      end else begin
         tbl = '0;
      end
      sref = tbl + hrae_pkg::OFS_90 + ((dir_ff != refdir_ff) ? hrae_pkg::OFS_60 : 16'd0);
   end

   assign low_speed = ($signed(ispd_ff) >= SLOW_N) && ($signed(ispd_ff) <= SLOW_P);

   // sector-5 pull and ordinary advance
   always_comb begin
      s    = step_ff;
      half = {1'b0, s[15:1]};
      dbl  = {s[14:0], 1'b0};
      fwd  = dir_ff == refdir_ff;
      th   = angle_ff;
      rf   = ref_ff;
      if (hall_ff == hrae_pkg::HALL_PULL) begin
         if (fwd) begin
            rf = ref_ff + s;
            if ($signed(angle_ff) > $signed(ref_ff)) begin
               th = angle_ff + half;
               if ($signed(th) <= $signed(rf)) th = rf;
            end else begin
               th = angle_ff + dbl;
               if ($signed(th) >= $signed(rf)) th = rf;
            end
         end else begin
            rf = ref_ff - s;
            if ($signed(angle_ff) < $signed(ref_ff)) begin
               th = angle_ff - half;
               if ($signed(th) >= $signed(rf)) th = rf;
            end else begin
               th = angle_ff - dbl;
               if ($signed(th) <= $signed(rf)) th = rf;
            end
         end
      end else begin
         th = fwd ? angle_ff + s : angle_ff - s;
      end
   end

   always_comb begin
      diff     = $signed({2'b00, iper_ff}) - $signed({{2{fp_ff[15]}}, fp_ff});
      sum      = $signed({acc_ff[31], acc_ff}) + $signed({{3{prod_ff[29]}}, prod_ff});
      angle_in = angle_ff;
      ref_in   = ref_ff;
      acc_in   = acc_ff;
      fp_in    = fp_ff;
      step_in  = step_ff;
      dir_in   = dir_ff;
      hall_in  = hall_ff;
      prev_in  = prev_ff;
      prod_in  = prod_ff;
      case (op)
         hrae_pkg::OP_INIT: begin
            hall_in  = ih_ff;
            angle_in = tbl + hrae_pkg::OFS_30 + hrae_pkg::OFS_90;
         end
         hrae_pkg::OP_EDGE_DIR: begin
            hall_in = ih_ff;
            prev_in = ih_ff;
            if (ih_ff inside {[3'd1:3'd6]}) begin
               if (hrae_pkg::fwd_next(prev_ff) == ih_ff) begin
                  dir_in = 1'b0;
               end else if (hrae_pkg::fwd_next(ih_ff) == prev_ff) begin
                  dir_in = 1'b1;
               end
            end
         end
         hrae_pkg::OP_EDGE_REF: ref_in = sref;
         hrae_pkg::OP_FILT_MUL: prod_in = 30'(diff) * 30'(GAIN_S);
         hrae_pkg::OP_FILT_ACC: begin
            if (sum >= BOUND_P) begin
               acc_in = BOUND_P[31:0];
            end else if (sum <= BOUND_N) begin
               acc_in = BOUND_N[31:0];
            end else begin
               acc_in = sum[31:0];
            end
         end
         hrae_pkg::OP_FILT_OUT: fp_in = acc_ff[30:15];   // floor of acc / 32768
         hrae_pkg::OP_CLAMP: begin
            if ($signed(fp_ff) < $signed(minp_ff)) begin
               fp_in = minp_ff + 16'd1;
            end
         end
         hrae_pkg::OP_STEP_SAT: begin
            step_in = (quo[hrae_pkg::DIV_W-1:16] != '0) ? 16'hFFFF : quo[15:0];
         end
         hrae_pkg::OP_MOVE: begin
            angle_in = th;
            ref_in   = rf;
         end
         hrae_pkg::OP_LOW_SPEED: begin
            step_in  = '0;
            angle_in = sref;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         ref_ff   <= '0;
         acc_ff   <= '0;
         fp_ff    <= '0;
         step_ff  <= '0;
         dir_ff   <= 1'b0;
         hall_ff  <= '0;
         prev_ff  <= '0;
      end else begin
         angle_ff <= angle_in;
         ref_ff   <= ref_in;
         acc_ff   <= acc_in;
         fp_ff    <= fp_in;
         step_ff  <= step_in;
         dir_ff   <= dir_in;
         hall_ff  <= hall_in;
         prev_ff  <= prev_in;
      end
      prod_ff <= prod_in;
   end

   assign result.angle           = angle_ff;
   assign result.direction       = dir_ff;
   assign result.angle_step      = step_ff;
   assign result.reference_angle = ref_ff;

endmodule

`default_nettype wire

// ===== sv/hall_rotor_angle_estimator.sv =====
// Hall rotor angle estimator, top level.
//
// Send one command item on req_ (command in req_tuser, hall code, period and
// speed in req_tdata); every command returns exactly one rsp_ item with the
// rotor angle, direction, angle step and sector reference angle.
// Configure the sector table, min period and reference direction through the
// csr_ write port while no command is in flight.
//
// A tick at low speed zeroes the angle step and sets the angle to the
// sector reference; a tick at speed waits on the bit-serial divide of the
// step constant by the filtered period. One item is worked on at a time:
// req_tready is high whenever the microprogram is idle, also while a result
// waits in the output register. If the receiver stalls, the next item runs
// up to its final step and holds there until the output register empties.
// Synchronous reset sets the min period to 100 and clears the sector angles,
// both directions and the angle, reference, accumulator, filtered period,
// step and hall registers; no item is in flight after reset.
`default_nettype none

module hall_rotor_angle_estimator #(
   parameter logic [31:0] ANGLE_STEP_CONST = 32'd268435456
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // hall_code[2:0], period[18:3], speed[34:19]
   input  wire logic [1:0]  req_tuser,   // command[1:0]
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // angle[15:0], direction[16],
                                         // angle_step[32:17], reference_angle[48:33]
   // configuration writes
   input  wire logic                              csr_we,
   input  wire logic [hrae_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [hrae_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                       busy, start, load;
   logic                       low_speed, div_busy;
   hrae_pkg::hrae_op_type      op;
   hrae_pkg::hrae_status_type  status;
   hrae_pkg::hrae_item_type    item;
   hrae_pkg::hrae_result_type  result;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [55:0]                rsp_data_ff, rsp_data_in;

   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;

   // unpack the item fields from the lowest bit up
   assign item.hall_code = req_tdata[2:0];
   assign item.period    = req_tdata[18:3];
   assign item.speed     = req_tdata[34:19];

   // low_speed, div_busy, out_free
   assign status = {low_speed, div_busy, !rsp_valid_ff || rsp_tready};

   hrae_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_tuser),
      .status  (status),
      .busy    (busy),
      .op      (op),
      .load    (load)
   );

   hrae_datapath #(
      .ANGLE_STEP_CONST (ANGLE_STEP_CONST)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item      (item),
      .op        (op),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .low_speed (low_speed),
      .div_busy  (div_busy),
      .result    (result)
   );

   // output register: load on the final step, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, result.reference_angle, result.angle_step,
                         result.direction, result.angle};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
